@@ rtl/hsbl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hsbl_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned RetryW = 3;
  localparam int unsigned StatW  = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CntW-1:0] BitsPerByte = CntW'(8);
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_TICKS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PREPARE_TIMEOUT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRANSFER_TIMEOUT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TICKS    = 3'd4;

  // reset values of the registers
  localparam logic [TimerW-1:0] RST_CONFIRM_TICKS    = 16'd200;
  localparam logic [TimerW-1:0] RST_PREPARE_TIMEOUT  = 16'd2000;
  localparam logic [TimerW-1:0] RST_TRANSFER_TIMEOUT = 16'd10000;
  localparam logic [RetryW-1:0] RST_RETRY_LIMIT      = 3'd5;
  localparam logic [TimerW-1:0] RST_RELEASE_TICKS    = 16'd100;

  // status codes
  localparam logic [StatW-1:0] ST_NONE         = 4'd0;
  localparam logic [StatW-1:0] ST_RX_BYTE      = 4'd1;
  localparam logic [StatW-1:0] ST_CONFIRM_FAIL = 4'd2;
  localparam logic [StatW-1:0] ST_RX_PREP_TO   = 4'd3;
  localparam logic [StatW-1:0] ST_RX_TO        = 4'd4;
  localparam logic [StatW-1:0] ST_TX_GAVE_UP   = 4'd5;
  localparam logic [StatW-1:0] ST_TX_TO        = 4'd6;
  localparam logic [StatW-1:0] ST_REJECTED     = 4'd7;
  localparam logic [StatW-1:0] ST_SENT         = 4'd8;

  typedef struct packed {
    logic [TimerW-1:0] confirm_ticks;
    logic [TimerW-1:0] prepare_timeout;
    logic [TimerW-1:0] transfer_timeout;
    logic [RetryW-1:0] retry_limit;
    logic [TimerW-1:0] release_ticks;
  } cfg_t;

  typedef struct packed {
    logic              select_line;
    logic              clock_line;
    logic              send_request;
    logic [ByteW-1:0]  tx_byte;
  } tick_t;

  typedef struct packed {
    logic              write_line;
    logic              busy_led;
    logic [ByteW-1:0]  rx_byte;
    logic [StatW-1:0]  status;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/hsbl_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hsbl_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire hsbl_pkg::tick_t tick,
  input  wire hsbl_pkg::cfg_t  cfg,
  output hsbl_pkg::res_t       res
);
  import hsbl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_RPREP   = 3'd2,
    PH_RRCV    = 3'd3,
    PH_SPREP   = 3'd4,
    PH_SENDING = 3'd5,
    PH_SENT    = 3'd6,
    PH_RELEASE = 3'd7
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TimerW-1:0] timer_r, timer_nxt, timer_grown;
  logic [ByteW-1:0]  shift_r, shift_nxt;
  logic [CntW-1:0]   bits_r, bits_nxt, bits_inc, bits_dec;
  logic [RetryW-1:0] retries_r, retries_nxt;
  logic              last_clk_r;
  logic              drive_r, drive_nxt;
  logic              rising, falling;
  logic [StatW-1:0]  status;
  logic [ByteW-1:0]  rxb;

  assign rising  = tick.clock_line & ~last_clk_r;
  assign falling = ~tick.clock_line & last_clk_r;
  assign timer_grown = (phase_r != PH_IDLE && timer_r != TimerMax) ?
                       timer_r + TimerW'(1) : timer_r;
  assign bits_inc = bits_r + CntW'(1);
  assign bits_dec = bits_r - CntW'(1);

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_grown;
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    retries_nxt = retries_r;
    drive_nxt   = drive_r;
    status      = ST_NONE;
    rxb         = '0;
    if (phase_r == PH_IDLE) begin
      if (!tick.select_line) begin
        // peer pulled select low: hold our line low and confirm
        phase_nxt = PH_CONFIRM;
        drive_nxt = 1'b0;
        timer_nxt = '0;
        if (tick.send_request) status = ST_REJECTED;
      end else if (tick.send_request) begin
        retries_nxt = '0;
        shift_nxt   = tick.tx_byte;
        bits_nxt    = BitsPerByte;
        phase_nxt   = PH_SPREP;
        drive_nxt   = 1'b0;
        timer_nxt   = '0;
      end
    end else begin
      if (tick.send_request) status = ST_REJECTED;
      unique case (phase_r)
        PH_CONFIRM: begin
          if (timer_grown >= cfg.confirm_ticks) begin
            if (!tick.select_line) begin
              phase_nxt = PH_RPREP;
              shift_nxt = '0;
              bits_nxt  = '0;
              timer_nxt = '0;
            end else begin
              phase_nxt = PH_IDLE;
              drive_nxt = 1'b1;
              status    = ST_CONFIRM_FAIL;
            end
          end
        end
        PH_RPREP: begin
          if (rising) begin
            // acknowledge; the receive timer keeps running
            drive_nxt = 1'b1;
            phase_nxt = PH_RRCV;
          end else if (timer_grown >= cfg.prepare_timeout) begin
            phase_nxt = PH_IDLE;
            drive_nxt = 1'b1;
            status    = ST_RX_PREP_TO;
          end
        end
        PH_RRCV: begin
          if (rising) begin
            shift_nxt = {shift_r[ByteW-2:0], tick.select_line};
            bits_nxt  = bits_inc;
            if (bits_inc >= BitsPerByte) begin
              phase_nxt = PH_IDLE;
              drive_nxt = 1'b1;
              status    = ST_RX_BYTE;
              rxb       = {shift_r[ByteW-2:0], tick.select_line};
            end
          end else if (timer_grown >= cfg.transfer_timeout) begin
            phase_nxt = PH_IDLE;
            drive_nxt = 1'b1;
            status    = ST_RX_TO;
          end
        end
        PH_SPREP: begin
          if (falling && !tick.select_line && timer_grown >= cfg.confirm_ticks) begin
            phase_nxt = PH_SENDING;
            timer_nxt = '0;
          end else if (timer_grown >= cfg.prepare_timeout) begin
            if (retries_r < cfg.retry_limit) begin
              // retry the prepare; the line stays low
              retries_nxt = retries_r + RetryW'(1);
              drive_nxt   = 1'b0;
              timer_nxt   = '0;
            end else begin
              phase_nxt = PH_IDLE;
              drive_nxt = 1'b1;
              status    = ST_TX_GAVE_UP;
            end
          end
        end
        PH_SENDING: begin
          if (falling && tick.select_line) begin
            drive_nxt = shift_r[bits_dec[2:0]];
            bits_nxt  = bits_dec;
            if (bits_dec == '0 || bits_dec > BitsPerByte) begin
              bits_nxt  = '0;
              phase_nxt = PH_SENT;
            end
          end else if (timer_grown >= cfg.transfer_timeout) begin
            phase_nxt = PH_IDLE;
            drive_nxt = 1'b1;
            status    = ST_TX_TO;
          end
        end
        PH_SENT: begin
          if (tick.clock_line) begin
            phase_nxt = PH_RELEASE;
            timer_nxt = '0;
          end
        end
        PH_RELEASE: begin
          if (timer_grown >= cfg.release_ticks) begin
            phase_nxt = PH_IDLE;
            drive_nxt = 1'b1;
            status    = ST_SENT;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign res.write_line = drive_nxt;
  assign res.busy_led   = (phase_nxt != PH_IDLE) && (phase_nxt != PH_CONFIRM);
  assign res.rx_byte    = rxb;
  assign res.status     = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      timer_r    <= '0;
      shift_r    <= '0;
      bits_r     <= '0;
      retries_r  <= '0;
      last_clk_r <= 1'b0;
      drive_r    <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      shift_r    <= shift_nxt;
      bits_r     <= bits_nxt;
      retries_r  <= retries_nxt;
      last_clk_r <= tick.clock_line;
      drive_r    <= drive_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/handshake_serial_byte_link.sv @@
// Half-duplex three-wire byte link engine, one beat per microsecond tick.
// Input channel (in_*): each beat carries the sampled peer select/data and
// clock lines plus an optional send request with its byte. The beat is
// taken when in_valid is high and in_stall is low.
// Result channel (out_*): exactly one beat per input beat, carrying the
// level to drive on our line, the busy flag, a received byte and a status
// code. It is taken when out_valid is high and out_stall is low.
// The result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless stalled; the whole tick (edge detect, timers,
// phase update) is one pass of logic into the result register.
// Stall: while a result is held in the result register and out_stall is
// high, in_stall goes high and the link state holds; a free or draining
// result register lets the next input beat in the same cycle.
// Reset (rst_n low, synchronous): link idle, line released high, timers
// and counters cleared, registers back to their defaults (confirm 200,
// prepare timeout 2000, transfer timeout 10000, retries 5, release 100).
// Configuration: write cfg_data to register cfg_index while cfg_we is
// high; only write while the link is idle.
`timescale 1ns / 1ps
`default_nettype none

module handshake_serial_byte_link (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_select_line,
  input  wire logic                         in_clock_line,
  input  wire logic                         in_send_request,
  input  wire logic [hsbl_pkg::ByteW-1:0]   in_tx_byte,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic                         out_write_line,
  output      logic                         out_busy_led,
  output      logic [hsbl_pkg::ByteW-1:0]   out_rx_byte,
  output      logic [hsbl_pkg::StatW-1:0]   out_status,
  input  wire logic                         cfg_we,
  input  wire logic [hsbl_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [hsbl_pkg::TimerW-1:0]  cfg_data
);
  import hsbl_pkg::*;

  cfg_t  cfg_r;
  tick_t tick;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  take;

  // hold the input while a finished result waits on a stalled receiver
  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  assign tick.select_line  = in_select_line;
  assign tick.clock_line   = in_clock_line;
  assign tick.send_request = in_send_request;
  assign tick.tx_byte      = in_tx_byte;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_ticks    <= RST_CONFIRM_TICKS;
      cfg_r.prepare_timeout  <= RST_PREPARE_TIMEOUT;
      cfg_r.transfer_timeout <= RST_TRANSFER_TIMEOUT;
      cfg_r.retry_limit      <= RST_RETRY_LIMIT;
      cfg_r.release_ticks    <= RST_RELEASE_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONFIRM_TICKS:    cfg_r.confirm_ticks    <= cfg_data;
        CFG_PREPARE_TIMEOUT:  cfg_r.prepare_timeout  <= cfg_data;
        CFG_TRANSFER_TIMEOUT: cfg_r.transfer_timeout <= cfg_data;
        CFG_RETRY_LIMIT:      cfg_r.retry_limit      <= cfg_data[RetryW-1:0];
        CFG_RELEASE_TICKS:    cfg_r.release_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // link state machine: advance one tick per accepted beat
  hsbl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .tick  (tick),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register: load on an accepted beat, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_write_line = res_r.write_line;
  assign out_busy_led   = res_r.busy_led;
  assign out_rx_byte    = res_r.rx_byte;
  assign out_status     = res_r.status;

endmodule

`default_nettype wire

@@ tb/handshake_serial_byte_link_tb.sv @@
`timescale 1ns / 1ps

module handshake_serial_byte_link_tb;
  import hsbl_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;

  // link phases as the predictor tracks them
  typedef enum logic [2:0] {
    LK_IDLE,
    LK_CONFIRM,
    LK_RX_PREP,
    LK_RX_SHIFT,
    LK_TX_PREP,
    LK_TX_SHIFT,
    LK_TX_DONE,
    LK_RELEASE
  } link_phase_t;

  typedef struct packed {
    link_phase_t       phase;
    logic [TimerW-1:0] timer;
    logic [ByteW-1:0]  shift;
    logic [CntW-1:0]   bits;
    logic [RetryW-1:0] retries;
    logic              last_clk;
    logic              drive;
  } link_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_select_line = 1'b1;
  logic             in_clock_line = 1'b0;
  logic             in_send_request = 1'b0;
  logic [ByteW-1:0] in_tx_byte = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_write_line;
  logic             out_busy_led;
  logic [ByteW-1:0] out_rx_byte;
  logic [StatW-1:0] out_status;

  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TimerW-1:0]  cfg_data = '0;

  // ticks waiting to be driven, and the results owed by accepted ticks
  tick_t pending_ticks[$];
  res_t  expected_results[$];

  // link_now follows accepted beats; link_ahead follows queued ticks so the
  // stimulus can play a protocol-aware peer
  link_state_t link_now;
  link_state_t link_ahead;
  cfg_t        link_cfg;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  tick_t beat_now;
  tick_t next_beat;
  res_t  oldest;

  assign beat_now = {in_select_line, in_clock_line, in_send_request, in_tx_byte};

  handshake_serial_byte_link dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_select_line (in_select_line),
    .in_clock_line  (in_clock_line),
    .in_send_request(in_send_request),
    .in_tx_byte     (in_tx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_write_line (out_write_line),
    .out_busy_led   (out_busy_led),
    .out_rx_byte    (out_rx_byte),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // One microsecond tick of the link: advance the state, return the line
  // levels and the status of this tick.
  function automatic res_t link_tick(inout link_state_t s, input cfg_t c, input tick_t t);
    res_t        r;
    logic        rising;
    logic        falling;
    link_phase_t ph;
    logic [2:0]  idx;
    rising = t.clock_line && !s.last_clk;
    falling = !t.clock_line && s.last_clk;
    ph = s.phase;
    r.status = ST_NONE;
    r.rx_byte = '0;
    s.last_clk = t.clock_line;
    if (ph != LK_IDLE && s.timer != TimerMax) s.timer = s.timer + 1'b1;

    if (ph == LK_IDLE) begin
      if (!t.select_line) begin
        // peer pulled select low: hold our line low and confirm
        s.phase = LK_CONFIRM;
        s.drive = 1'b0;
        s.timer = '0;
        if (t.send_request) r.status = ST_REJECTED;
      end else if (t.send_request) begin
        s.retries = '0;
        s.shift = t.tx_byte;
        s.bits = BitsPerByte;
        s.phase = LK_TX_PREP;
        s.drive = 1'b0;
        s.timer = '0;
      end
    end else begin
      if (t.send_request) r.status = ST_REJECTED;
      case (ph)
        LK_CONFIRM: begin
          if (s.timer >= c.confirm_ticks) begin
            if (!t.select_line) begin
              s.phase = LK_RX_PREP;
              s.shift = '0;
              s.bits = '0;
              s.timer = '0;
            end else begin
              s.phase = LK_IDLE;
              s.drive = 1'b1;
              r.status = ST_CONFIRM_FAIL;
            end
          end
        end
        LK_RX_PREP: begin
          // first rising edge is the acknowledge, not a data bit
          if (rising) begin
            s.drive = 1'b1;
            s.phase = LK_RX_SHIFT;
          end else if (s.timer >= c.prepare_timeout) begin
            s.phase = LK_IDLE;
            s.drive = 1'b1;
            r.status = ST_RX_PREP_TO;
          end
        end
        LK_RX_SHIFT: begin
          if (rising) begin
            s.shift = {s.shift[ByteW-2:0], t.select_line};
            s.bits = s.bits + 1'b1;
            if (s.bits >= BitsPerByte) begin
              s.phase = LK_IDLE;
              s.drive = 1'b1;
              r.status = ST_RX_BYTE;
              r.rx_byte = s.shift;
            end
          end else if (s.timer >= c.transfer_timeout) begin
            s.phase = LK_IDLE;
            s.drive = 1'b1;
            r.status = ST_RX_TO;
          end
        end
        LK_TX_PREP: begin
          if (falling && !t.select_line && s.timer >= c.confirm_ticks) begin
            s.phase = LK_TX_SHIFT;
            s.timer = '0;
          end else if (s.timer >= c.prepare_timeout) begin
            // retry keeps the count of retries already used
            if (s.retries < c.retry_limit) begin
              s.retries = s.retries + 1'b1;
              s.drive = 1'b0;
              s.timer = '0;
            end else begin
              s.phase = LK_IDLE;
              s.drive = 1'b1;
              r.status = ST_TX_GAVE_UP;
            end
          end
        end
        LK_TX_SHIFT: begin
          if (falling && t.select_line) begin
            idx = 3'(s.bits - 1'b1);
            s.drive = s.shift[idx];
            s.bits = s.bits - 1'b1;
            if (s.bits == 0 || s.bits > BitsPerByte) begin
              s.bits = '0;
              s.phase = LK_TX_DONE;
            end
          end else if (s.timer >= c.transfer_timeout) begin
            s.phase = LK_IDLE;
            s.drive = 1'b1;
            r.status = ST_TX_TO;
          end
        end
        LK_TX_DONE: begin
          // no limit here: wait for the clock to come back high
          if (t.clock_line) begin
            s.phase = LK_RELEASE;
            s.timer = '0;
          end
        end
        LK_RELEASE: begin
          if (s.timer >= c.release_ticks) begin
            s.phase = LK_IDLE;
            s.drive = 1'b1;
            r.status = ST_SENT;
          end
        end
        default: ;
      endcase
    end

    r.write_line = s.drive;
    r.busy_led = (s.phase != LK_IDLE && s.phase != LK_CONFIRM);
    return r;
  endfunction

  // Pick the next tick as a peer would, from where the link will be.
  // pace is the chance in percent that the peer clock moves this tick;
  // eager forces progress back to idle with no detours.
  function automatic tick_t peer_tick(input link_state_t s, input cfg_t c,
                                      input int unsigned pace, input bit eager);
    tick_t             t;
    bit                flip;
    int unsigned       roll;
    logic [TimerW-1:0] next_timer;
    t.select_line = 1'b1;
    t.clock_line = s.last_clk;
    t.send_request = 1'b0;
    t.tx_byte = ByteW'($urandom);
    flip = eager || ($urandom_range(99) < pace);
    roll = $urandom_range(99);
    next_timer = (s.timer == TimerMax) ? s.timer : s.timer + 1'b1;
    case (s.phase)
      LK_IDLE: begin
        if (roll < 35) begin
          t.select_line = 1'b0;
        end else if (roll < 40) begin
          t.select_line = 1'b0;
          t.send_request = 1'b1;
        end else if (roll < 75) begin
          t.send_request = 1'b1;
        end else begin
          t.clock_line = 1'($urandom_range(1));
        end
      end
      LK_CONFIRM: t.select_line = !eager && roll >= 90;
      LK_RX_PREP, LK_RX_SHIFT: begin
        t.select_line = 1'($urandom_range(1));
        if (flip) t.clock_line = !s.last_clk;
      end
      LK_TX_PREP: begin
        t.select_line = 1'b0;
        if (eager || roll < 70) begin
          // hold the clock high until settling is over, then drop it
          t.clock_line = !(next_timer >= c.confirm_ticks && s.last_clk && flip);
        end else if (flip) begin
          t.clock_line = !s.last_clk;
        end
      end
      LK_TX_SHIFT: begin
        t.select_line = eager || roll < 95;
        if (flip) t.clock_line = !s.last_clk;
      end
      LK_TX_DONE: if (flip) t.clock_line = 1'b1;
      default: ;
    endcase
    // now and then ask to send while busy
    if (!eager && s.phase != LK_IDLE && $urandom_range(99) < 4) t.send_request = 1'b1;
    return t;
  endfunction

  function automatic cfg_t make_cfg(input logic [TimerW-1:0] confirm,
                                    input logic [TimerW-1:0] prepare,
                                    input logic [TimerW-1:0] transfer,
                                    input logic [RetryW-1:0] retry,
                                    input logic [TimerW-1:0] release_delay);
    cfg_t c;
    c.confirm_ticks = confirm;
    c.prepare_timeout = prepare;
    c.transfer_timeout = transfer;
    c.retry_limit = retry;
    c.release_ticks = release_delay;
    return c;
  endfunction

  task automatic queue_tick(input tick_t t);
    void'(link_tick(link_ahead, link_cfg, t));
    pending_ticks.push_back(t);
  endtask

  task automatic queue_fields(input logic sel, input logic pclk, input logic req,
                              input logic [ByteW-1:0] data);
    tick_t t;
    t.select_line = sel;
    t.clock_line = pclk;
    t.send_request = req;
    t.tx_byte = data;
    queue_tick(t);
  endtask

  // Let the peer cooperate until the link is back in idle.
  task automatic drain_link();
    while (link_ahead.phase != LK_IDLE) queue_tick(peer_tick(link_ahead, link_cfg, 100, 1'b1));
  endtask

  task automatic run_link_traffic(input int unsigned count);
    tick_t       t;
    int unsigned pace;
    pace = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) pace = $urandom_range(10, 100);
      if ($urandom_range(99) < 8) begin
        // raw noise on every field
        t.select_line = 1'($urandom_range(1));
        t.clock_line = 1'($urandom_range(1));
        t.send_request = 1'($urandom_range(1));
        t.tx_byte = ByteW'($urandom);
      end else begin
        t = peer_tick(link_ahead, link_cfg, pace, 1'b0);
      end
      queue_tick(t);
    end
    drain_link();
  endtask

  // Sample at the falling edge so queue and valid updates of the rising
  // edge have all landed.
  task automatic wait_link_quiet();
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimerW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic load_settings(input cfg_t c);
    link_cfg = c;
    write_reg(CFG_CONFIRM_TICKS, c.confirm_ticks);
    write_reg(CFG_PREPARE_TIMEOUT, c.prepare_timeout);
    write_reg(CFG_TRANSFER_TIMEOUT, c.transfer_timeout);
    write_reg(CFG_RETRY_LIMIT, TimerW'(c.retry_limit));
    write_reg(CFG_RELEASE_TICKS, c.release_ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string field, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: got %0d expected %0d", $time, field, got, want);
    end
  endtask

  // Driver: on an accepted beat, predict its result; load the next tick
  // whenever the input slot is free, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(link_tick(link_now, link_cfg, beat_now));
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_ticks.pop_front();
          in_valid <= 1'b1;
          in_select_line <= next_beat.select_line;
          in_clock_line <= next_beat.clock_line;
          in_send_request <= next_beat.send_request;
          in_tx_byte <= next_beat.tx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result beat against the oldest prediction,
  // then choose whether to stall the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result beat with nothing expected", $time);
        end else begin
          oldest = expected_results.pop_front();
          check_field("write_line", 32'(out_write_line), 32'(oldest.write_line));
          check_field("busy_led", 32'(out_busy_led), 32'(oldest.busy_led));
          check_field("rx_byte", 32'(out_rx_byte), 32'(oldest.rx_byte));
          check_field("status", 32'(out_status), 32'(oldest.status));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("handshake_serial_byte_link_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t        setting;
    logic [7:0]  pattern;
    int unsigned mode;
    link_now = '{phase: LK_IDLE, timer: '0, shift: '0, bits: '0, retries: '0,
                 last_clk: 1'b0, drive: 1'b1};
    link_ahead = link_now;
    link_cfg = make_cfg(RST_CONFIRM_TICKS, RST_PREPARE_TIMEOUT, RST_TRANSFER_TIMEOUT,
                        RST_RETRY_LIMIT, RST_RELEASE_TICKS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Run on the reset settings first.
    run_link_traffic(150);
    wait_link_quiet();

    // Directed beats on short timers.
    load_settings(make_cfg(16'd2, 16'd6, 16'd30, 3'd1, 16'd3));
    queue_fields(1'b1, 1'b1, 1'b0, 8'h00);
    // send request in the tick select is first seen low: rejected
    queue_fields(1'b0, 1'b1, 1'b1, 8'hFF);
    // select back high when the confirm time is up: confirm fails
    queue_fields(1'b1, 1'b1, 1'b0, 8'h00);
    queue_fields(1'b1, 1'b1, 1'b0, 8'h00);
    // full receive of one byte, with a request while busy midway
    repeat (3) queue_fields(1'b0, 1'b0, 1'b0, 8'h00);
    queue_fields(1'b0, 1'b1, 1'b0, 8'h00);
    pattern = 8'hA5;
    for (int b = 7; b >= 0; b--) begin
      queue_fields(pattern[b], 1'b0, b == 4, 8'h5A);
      queue_fields(pattern[b], 1'b1, 1'b0, 8'h00);
    end
    // send both extreme bytes through to release
    queue_fields(1'b1, 1'b1, 1'b1, 8'hFF);
    drain_link();
    queue_fields(1'b1, 1'b1, 1'b1, 8'h00);
    drain_link();
    wait_link_quiet();

    // Random traffic over several settings and idling patterns.
    for (int k = 0; k < 7; k++) begin
      case (k)
        1: setting = make_cfg(16'd1, 16'd1, 16'd1, 3'd0, 16'd1);
        // zero limits behave as one
        3: setting = make_cfg(16'd0, 16'd0, 16'd0, 3'($urandom_range(7)), 16'd0);
        // longest timeouts and retries, short settle and release
        5: setting = make_cfg(16'd3, TimerMax, TimerMax, 3'd7, 16'd4);
        default: setting = make_cfg(16'($urandom_range(1, 12)), 16'($urandom_range(1, 50)),
                                    16'($urandom_range(2, 120)), 3'($urandom_range(7)),
                                    16'($urandom_range(1, 16)));
      endcase
      load_settings(setting);
      // keep the long-timeout phase short and free of idling
      mode = (k == 5) ? 0 : k % 4;
      send_idle_pct = (mode == 1) ? 81 : (mode == 3) ? 32 : 0;
      recv_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 32 : 0;
      run_link_traffic((k == 5) ? 40 : 300);
      wait_link_quiet();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("handshake_serial_byte_link_tb: PASS");
    end else begin
      $display("handshake_serial_byte_link_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hsbl_pkg.sv
rtl/hsbl_core.sv
rtl/handshake_serial_byte_link.sv
tb/handshake_serial_byte_link_tb.sv
